// ===== rtl/core/uv_sphere_vertex_generator_core_macros.svh =====
// assertion macros for the sphere vertex core checker
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH

// checked only outside reset
`define UVS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("uvs check failed");

// checked at every edge, reset included
`define UVS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("uvs check failed");

`endif

// ===== rtl/core/uvs_pkg.sv =====
package uvs_pkg;

    localparam int CNT_W     = 11;
    localparam int MAX_SEG   = 1024;
    localparam int FRAC_BITS = 16;
    localparam int TRIG_BITS = 30;
    localparam int PHASE_W   = 32;
    localparam int QUO_W     = PHASE_W + 1;
    localparam int MAG_W     = TRIG_BITS + 1;
    localparam int TEX_W     = FRAC_BITS + 1;
    localparam int RAD_W     = 24;
    localparam int POS_W     = 25;
    localparam int NRM_W     = 18;

    localparam logic [MAG_W-1:0]   TRIG_ONE    = 31'h4000_0000;
    localparam logic [63:0]        HALF64      = 64'h2000_0000;
    localparam logic [MAG_W-1:0]   HALF_PI_Q30 = 31'd1686629713;
    localparam logic [PHASE_W-1:0] QUARTER     = 32'h4000_0000;

    // long division: integer step, then DIV_BITS fraction bits per stage
    localparam int DIV_BITS      = 4;
    localparam int DIV_STAGES    = PHASE_W / DIV_BITS;
    localparam int DIV_TEX_STAGE = FRAC_BITS / DIV_BITS - 1;
    localparam int DIV_LAT       = DIV_STAGES + 1;

    // sine: fold, x, x squared, three stages per horner step, final product
    localparam int HORNER_STEPS = 6;
    localparam int SINE_LAT     = 3 + 3 * HORNER_STEPS + 1;

    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_STACKS  = 2'd1;
    localparam logic [1:0] CFG_SECTORS = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_sine;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [CNT_W-1:0] rem;
        logic [TEX_W-1:0] quo16;
        logic [CNT_W-1:0] rem16;
    } t_div_res;

    function automatic logic [7:0] horner_div(input logic [2:0] k);
        case (k)
            3'd0:    return 8'd156;
            3'd1:    return 8'd110;
            3'd2:    return 8'd72;
            3'd3:    return 8'd42;
            3'd4:    return 8'd20;
            default: return 8'd6;
        endcase
    endfunction

    // floor(2^32 / d) but d = 156 is set lower; estimate gets one correction
    function automatic logic [31:0] horner_recip(input logic [2:0] k);
        case (k)
            3'd0:    return 32'd27531829;
            3'd1:    return 32'd39045157;
            3'd2:    return 32'd59652323;
            3'd3:    return 32'd102261126;
            3'd4:    return 32'd214748364;
            default: return 32'd715827882;
        endcase
    endfunction

endpackage

// ===== rtl/core/uvs_div.sv =====
module uvs_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [uvs_pkg::CNT_W-1:0] i_num,
    input  logic [uvs_pkg::CNT_W-1:0] i_den,
    output uvs_pkg::t_div_res         o_res
);

    localparam int CW = uvs_pkg::CNT_W;
    localparam int QW = uvs_pkg::QUO_W;
    localparam int NS = uvs_pkg::DIV_STAGES;

    logic [CW-1:0]              r_rem [0:NS];
    logic [QW-1:0]              r_quo [0:NS];
    logic [uvs_pkg::TEX_W-1:0]  r_q16 [0:NS];
    logic [CW-1:0]              r_r16 [0:NS];
    logic [QW+CW-1:0]           w_step [0:NS-1];
    logic                       w_ge;

    function automatic logic [QW+CW-1:0] div_steps(input logic [QW-1:0] quo,
                                                   input logic [CW-1:0] rem,
                                                   input logic [CW-1:0] den);
        logic [QW-1:0] q;
        logic [CW-1:0] r;
        logic [CW:0]   dbl;
        q = quo;
        r = rem;
        for (int b = 0; b < uvs_pkg::DIV_BITS; b++) begin
            dbl = {r, 1'b0};
            if (dbl >= {1'b0, den}) begin
                r = CW'(dbl - {1'b0, den});
                q = {q[QW-2:0], 1'b1};
            end else begin
                r = dbl[CW-1:0];
                q = {q[QW-2:0], 1'b0};
            end
        end
        return {q, r};
    endfunction

    assign w_ge = i_num >= i_den;

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            w_step[s] = div_steps(r_quo[s], r_rem[s], i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // numerator never exceeds the divisor: integer part is one bit
            r_rem[0] <= w_ge ? CW'(i_num - i_den) : i_num;
            r_quo[0] <= {{(QW-1){1'b0}}, w_ge};
            r_q16[0] <= '0;
            r_r16[0] <= '0;
            for (int s = 0; s < NS; s++) begin
                r_quo[s+1] <= w_step[s][QW+CW-1:CW];
                r_rem[s+1] <= w_step[s][CW-1:0];
                if (s == uvs_pkg::DIV_TEX_STAGE) begin
                    r_q16[s+1] <= w_step[s][CW+uvs_pkg::TEX_W-1:CW];
                    r_r16[s+1] <= w_step[s][CW-1:0];
                end else begin
                    r_q16[s+1] <= r_q16[s];
                    r_r16[s+1] <= r_r16[s];
                end
            end
        end
    end

    always_comb begin
        o_res.quo   = r_quo[NS];
        o_res.rem   = r_rem[NS];
        o_res.quo16 = r_q16[NS];
        o_res.rem16 = r_r16[NS];
    end

endmodule

// ===== rtl/core/uvs_sine.sv =====
module uvs_sine (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [uvs_pkg::PHASE_W-1:0] i_phase,
    output uvs_pkg::t_sine              o_sin
);

    localparam int H  = uvs_pkg::HORNER_STEPS;
    localparam int MW = uvs_pkg::MAG_W;

    logic [MW-1:0] r_1r;
    logic          r_1n;
    logic [MW-1:0] r_2x;
    logic          r_2n;

    // chain of horner steps, index 0 holds the x squared stage
    logic [MW-1:0] r_cx  [0:H];
    logic [31:0]   r_cx2 [0:H];
    logic          r_cn  [0:H];
    logic [MW-1:0] r_ct  [0:H];

    logic [31:0]   r_av  [0:H-1];
    logic [MW-1:0] r_ax  [0:H-1];
    logic [31:0]   r_ax2 [0:H-1];
    logic          r_an  [0:H-1];

    logic [31:0]   r_bv  [0:H-1];
    logic [31:0]   r_bq  [0:H-1];
    logic [MW-1:0] r_bx  [0:H-1];
    logic [31:0]   r_bx2 [0:H-1];
    logic          r_bn  [0:H-1];

    logic [63:0]   w_ap  [0:H-1];
    logic [63:0]   w_bp  [0:H-1];
    logic [31:0]   w_rem [0:H-1];
    logic [31:0]   w_q   [0:H-1];

    logic [MW-1:0] w_fold;
    logic [63:0]   w_xp;
    logic [63:0]   w_x2p;
    logic [63:0]   w_sp;
    logic [MW-1:0] r_mag;
    logic          r_neg;

    // odd quadrants mirror about the quarter turn
    assign w_fold = i_phase[30] ? uvs_pkg::TRIG_ONE - {1'b0, i_phase[29:0]}
                                : {1'b0, i_phase[29:0]};
    assign w_xp  = 64'(r_1r) * 64'(uvs_pkg::HALF_PI_Q30) + uvs_pkg::HALF64;
    assign w_x2p = 64'(r_2x) * 64'(r_2x) + uvs_pkg::HALF64;
    assign w_sp  = 64'(r_cx[H]) * 64'(r_ct[H]) + uvs_pkg::HALF64;

    always_comb begin
        for (int k = 0; k < H; k++) begin
            w_ap[k]  = 64'(r_cx2[k]) * 64'(r_ct[k]) + uvs_pkg::HALF64;
            w_bp[k]  = 64'(r_av[k]) * 64'(uvs_pkg::horner_recip(3'(k)));
            w_rem[k] = r_bv[k] - 32'(r_bq[k] * 32'(uvs_pkg::horner_div(3'(k))));
            w_q[k]   = r_bq[k] + 32'(w_rem[k] >= 32'(uvs_pkg::horner_div(3'(k))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_1r <= w_fold;
            r_1n <= i_phase[31];
            r_2x <= w_xp[60:30];
            r_2n <= r_1n;
            r_cx[0]  <= r_2x;
            r_cx2[0] <= w_x2p[61:30];
            r_cn[0]  <= r_2n;
            r_ct[0]  <= uvs_pkg::TRIG_ONE;
            for (int k = 0; k < H; k++) begin
                r_av[k]  <= w_ap[k][61:30];
                r_ax[k]  <= r_cx[k];
                r_ax2[k] <= r_cx2[k];
                r_an[k]  <= r_cn[k];
                r_bv[k]  <= r_av[k];
                r_bq[k]  <= w_bp[k][63:32];
                r_bx[k]  <= r_ax[k];
                r_bx2[k] <= r_ax2[k];
                r_bn[k]  <= r_an[k];
                r_ct[k+1]  <= uvs_pkg::TRIG_ONE - MW'(w_q[k]);
                r_cx[k+1]  <= r_bx[k];
                r_cx2[k+1] <= r_bx2[k];
                r_cn[k+1]  <= r_bn[k];
            end
            r_mag <= (w_sp[61:30] > 32'(uvs_pkg::TRIG_ONE)) ? uvs_pkg::TRIG_ONE
                                                             : w_sp[60:30];
            r_neg <= r_cn[H];
        end
    end

    assign o_sin.neg = r_neg;
    assign o_sin.mag = r_mag;

endmodule

// ===== rtl/core/uv_sphere_vertex_generator_core.sv =====
// channel   dir   beat fields (lowest bits first)
// s_axis    in    stack_index, sector_index
// m_axis    out   pos_x/y/z, normal_x/y/z, tex_u, tex_v
// cfg       in    register index, write data
//
// one vertex per cycle while m_axis does not stall; latency from input beat to
// output beat is set by the 9-stage long divider and the 22-stage sine pipeline
// synchronous active-low reset clears valid bits and loads register defaults
// a stall on m_axis freezes the whole pipeline; s_axis ready drops with it
module uv_sphere_vertex_generator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [10:0] stack_index, [21:11] sector_index
    input  logic [23:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [24:0] pos_x, [49:25] pos_y, [74:50] pos_z, [92:75] normal_x,
    // [110:93] normal_y, [128:111] normal_z, [145:129] tex_u, [162:146] tex_v
    output logic [167:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);

    localparam int CW  = uvs_pkg::CNT_W;
    localparam int TW  = uvs_pkg::TEX_W;
    localparam int MW  = uvs_pkg::MAG_W;
    localparam int PW  = uvs_pkg::POS_W;
    localparam int NW  = uvs_pkg::NRM_W;
    localparam int SL  = uvs_pkg::SINE_LAT;
    localparam int LAT = 1 + uvs_pkg::DIV_LAT + 1 + SL + 2;
    localparam int NSH = uvs_pkg::TRIG_BITS - uvs_pkg::FRAC_BITS;

    // configuration registers
    logic [uvs_pkg::RAD_W-1:0] r_radius;
    logic [CW-1:0]             r_stack_total;
    logic [CW-1:0]             r_sector_total;
    logic [CW-1:0]             w_stacks;
    logic [CW-1:0]             w_sectors;

    logic                      w_en;
    logic [LAT-1:0]            r_vld;

    logic [CW-1:0]             w_in_stk;
    logic [CW-1:0]             w_in_sec;
    logic [CW-1:0]             r_stk;
    logic [CW-1:0]             r_sec;

    uvs_pkg::t_div_res         w_dstk;
    uvs_pkg::t_div_res         w_dsec;

    logic [CW:0]               w_r31;
    logic                      w_rnd_ps;
    logic                      w_rnd_pt;
    logic                      w_rnd_tu;
    logic                      w_rnd_tv;
    logic [31:0]               r_ps;
    logic [31:0]               r_pt;
    logic [2*TW-1:0]           r_tex;
    logic [2*TW-1:0]           r_tex_dly [0:SL];

    uvs_pkg::t_sine            w_ss;
    uvs_pkg::t_sine            w_cs;
    uvs_pkg::t_sine            w_st;
    uvs_pkg::t_sine            w_ct;
    logic [63:0]               w_dxp;
    logic [63:0]               w_dzp;
    uvs_pkg::t_sine            r_dir [0:2];

    logic [63:0]               w_pp  [0:2];
    logic [31:0]               w_np  [0:2];
    logic [PW-1:0]             w_pos [0:2];
    logic [NW-1:0]             w_nrm [0:2];
    logic [167:0]              r_out;

    // counts in effect: zero acts as one, above the limit clamps
    assign w_stacks  = (r_stack_total == '0) ? CW'(1)
                     : (r_stack_total > CW'(uvs_pkg::MAX_SEG)) ? CW'(uvs_pkg::MAX_SEG)
                     : r_stack_total;
    assign w_sectors = (r_sector_total == '0) ? CW'(1)
                     : (r_sector_total > CW'(uvs_pkg::MAX_SEG)) ? CW'(uvs_pkg::MAX_SEG)
                     : r_sector_total;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= 24'd65536;
            r_stack_total  <= 11'd18;
            r_sector_total <= 11'd36;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uvs_pkg::CFG_RADIUS:  r_radius       <= i_cfg_data;
                uvs_pkg::CFG_STACKS:  r_stack_total  <= i_cfg_data[CW-1:0];
                uvs_pkg::CFG_SECTORS: r_sector_total <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output slot is free or being drained
    assign w_en            = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // stage 0: saturate indices to the counts
    assign w_in_stk = i_s_axis_tdata[CW-1:0];
    assign w_in_sec = i_s_axis_tdata[2*CW-1:CW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stk <= (w_in_stk > w_stacks) ? w_stacks : w_in_stk;
            r_sec <= (w_in_sec > w_sectors) ? w_sectors : w_in_sec;
        end
    end

    // index * 2^32 / count, with the 2^16 partial result kept for tex
    uvs_div u_div_stk (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_stk),
        .i_den (w_stacks),
        .o_res (w_dstk)
    );

    uvs_div u_div_sec (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_sec),
        .i_den (w_sectors),
        .o_res (w_dsec)
    );

    // rounding: quotient plus one where remainder + count/2 reaches the count
    // stack phase is over 2^31, so halve the quotient and rebuild its remainder
    assign w_r31    = ({1'b0, w_dstk.rem} + (w_dstk.quo[0] ? {1'b0, w_stacks} : '0)) >> 1;
    assign w_rnd_ps = (w_r31 + {1'b0, w_stacks >> 1}) >= {1'b0, w_stacks};
    assign w_rnd_pt = ({1'b0, w_dsec.rem} + {1'b0, w_sectors >> 1}) >= {1'b0, w_sectors};
    assign w_rnd_tv = ({1'b0, w_dstk.rem16} + {1'b0, w_stacks >> 1}) >= {1'b0, w_stacks};
    assign w_rnd_tu = ({1'b0, w_dsec.rem16} + {1'b0, w_sectors >> 1}) >= {1'b0, w_sectors};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ps  <= w_dstk.quo[32:1] + 32'(w_rnd_ps);
            // sector phase wraps at the seam
            r_pt  <= w_dsec.quo[31:0] + 32'(w_rnd_pt);
            r_tex <= {w_dstk.quo16 + TW'(w_rnd_tv), w_dsec.quo16 + TW'(w_rnd_tu)};
            r_tex_dly[0] <= r_tex;
            for (int k = 1; k <= SL; k++) begin
                r_tex_dly[k] <= r_tex_dly[k-1];
            end
        end
    end

    // four sine lanes, cosine as a quarter turn ahead
    uvs_sine u_sin_s (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_ps),
        .o_sin   (w_ss)
    );

    uvs_sine u_cos_s (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_ps + uvs_pkg::QUARTER),
        .o_sin   (w_cs)
    );

    uvs_sine u_sin_t (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_pt),
        .o_sin   (w_st)
    );

    uvs_sine u_cos_t (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_pt + uvs_pkg::QUARTER),
        .o_sin   (w_ct)
    );

    // direction in sign-magnitude q2.30
    assign w_dxp = 64'(w_ss.mag) * 64'(w_st.mag) + uvs_pkg::HALF64;
    assign w_dzp = 64'(w_ss.mag) * 64'(w_ct.mag) + uvs_pkg::HALF64;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dir[0].neg <= w_ss.neg ^ w_st.neg;
            r_dir[0].mag <= w_dxp[60:30];
            r_dir[1]     <= w_cs;
            r_dir[2].neg <= w_ss.neg ^ w_ct.neg;
            r_dir[2].mag <= w_dzp[60:30];
        end
    end

    // scale by radius and narrow to the normal format
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pp[i]  = 64'(r_radius) * 64'(r_dir[i].mag) + uvs_pkg::HALF64;
            w_np[i]  = 32'(r_dir[i].mag) + (32'd1 << (NSH - 1));
            w_pos[i] = r_dir[i].neg ? PW'(0) - w_pp[i][PW+29:30] : w_pp[i][PW+29:30];
            w_nrm[i] = r_dir[i].neg ? NW'(0) - NW'(w_np[i] >> NSH) : NW'(w_np[i] >> NSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= {5'd0, r_tex_dly[SL], w_nrm[2], w_nrm[1], w_nrm[0],
                      w_pos[2], w_pos[1], w_pos[0]};
        end
    end

    assign o_m_axis_tdata = r_out;

endmodule

// ===== rtl/core/uvs_check.sv =====
`include "uv_sphere_vertex_generator_core_macros.svh"

module uvs_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [167:0] o_m_axis_tdata
);

    `UVS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))

    `UVS_ASSERT(a_ready_follows, i_clk, i_rst_n, i_m_axis_tready |-> o_s_axis_tready)

    `UVS_ASSERT(a_tex_range, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[145:129] <= 17'd65536) && (o_m_axis_tdata[162:146] <= 17'd65536))

    `UVS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind uv_sphere_vertex_generator_core uvs_check u_uvs_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
